>>> sv/grd_pkg.sv
// Shared types, widths and constants for the gyro ramp detector.
package grd_pkg;

	localparam int HISTORY_DEPTH = 16;

	localparam int SAMPLE_W   = 16;
	localparam int RATE_W     = 8;
	localparam int ANGLE_W    = 16;
	localparam int LIMIT_W    = 16;
	localparam int THRESH_W   = 15;
	localparam int RELOAD_W   = 8;
	localparam int RAMP_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int QUOT_W = 7;
	localparam int RUN_W  = LIMIT_W + 1;

	localparam int                DIV1000_SHIFT = 26;
	localparam int                PROD1_W       = SAMPLE_W + 17;
	localparam logic [16:0]       DIV1000_MUL   = 17'd67109;

	localparam int                SUM_W         = 11;
	localparam int                MAG2_W        = 10;
	localparam int                DIV10_SHIFT   = 13;
	localparam int                PROD2_W       = 20;
	localparam logic [MAG2_W-1:0] DIV10_MUL     = 10'd820;

	localparam logic [SAMPLE_W-1:0] RATE_OFFSET_RST     = 16'd0;
	localparam logic [LIMIT_W-1:0]  FLAT_TICK_LIMIT_RST = 16'd100;
	localparam logic [THRESH_W-1:0] RAMP_THRESHOLD_RST  = 15'd100;
	localparam logic [RELOAD_W-1:0] LOCKOUT_RELOAD_RST  = 8'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATE_OFFSET     = 2'd0,
		CFG_FLAT_TICK_LIMIT = 2'd1,
		CFG_RAMP_THRESHOLD  = 2'd2,
		CFG_LOCKOUT_RELOAD  = 2'd3
	} cfg_idx_t;

	typedef enum logic [RAMP_W-1:0] {
		RAMP_NONE = 2'd0,
		RAMP_FALL = 2'd1,
		RAMP_RISE = 2'd2
	} ramp_kind_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] rate_offset;
		logic [LIMIT_W-1:0]  flat_tick_limit;
		logic [THRESH_W-1:0] ramp_threshold;
		logic [RELOAD_W-1:0] lockout_reload;
	} cfg_t;

endpackage

>>> sv/grd_ifs.sv
// Channel interfaces: configuration writes, samples, filtered rate and results.
interface grd_cfg_if import grd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

interface grd_sample_if import grd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface grd_rate_if import grd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] rate;

	modport source (output valid, output rate, input ready);
	modport sink   (input valid, input rate, output ready);
endinterface

interface grd_result_if import grd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [RATE_W-1:0]  filtered_rate;
	logic signed [ANGLE_W-1:0] angle;
	logic                      flat_flag;
	logic [RAMP_W-1:0]         ramp_kind;
	logic                      lockout_flag;

	modport source (output valid, output filtered_rate, output angle, output flat_flag,
		output ramp_kind, output lockout_flag, input ready);
	modport sink   (input valid, input filtered_rate, input angle, input flat_flag,
		input ramp_kind, input lockout_flag, output ready);
endinterface

>>> sv/grd_rate_front.sv
// Offset removal, divide by 1000 and first-order low-pass of the gyro rate.
module grd_rate_front import grd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	grd_sample_if.sink    samples,
	grd_rate_if.source    rate
);

	logic                     v_s1;
	logic signed [RATE_W-1:0] scaled_s1;
	logic                     v_s2;
	logic signed [RATE_W-1:0] rate_filter_q;
	logic                     ready2;

	logic signed [SAMPLE_W:0] diff1;
	logic [SAMPLE_W:0]        neg_diff1;
	logic [SAMPLE_W-1:0]      mag1;
	logic [PROD1_W-1:0]       prod1;
	logic [RATE_W-1:0]        q1;
	logic [RATE_W-1:0]        scaled_next;

	logic signed [SUM_W-1:0]  old_ext;
	logic signed [SUM_W-1:0]  new_ext;
	logic signed [SUM_W-1:0]  sum2;
	logic [SUM_W-1:0]         neg_sum2;
	logic [MAG2_W-1:0]        mag2;
	logic [PROD2_W-1:0]       prod2;
	logic [RATE_W-1:0]        q2;
	logic [RATE_W-1:0]        filt_next;

	assign ready2        = !v_s2 || rate.ready;
	assign samples.ready = !v_s1 || ready2;
	assign rate.valid    = v_s2;
	assign rate.rate     = rate_filter_q;

	// divide magnitude by 1000 through the reciprocal, then restore the sign
	always_comb begin
		diff1       = signed'({1'b0, samples.sample}) - signed'({1'b0, cfg.rate_offset});
		neg_diff1   = -diff1;
		mag1        = diff1[SAMPLE_W] ? neg_diff1[SAMPLE_W-1:0] : diff1[SAMPLE_W-1:0];
		prod1       = PROD1_W'(mag1) * PROD1_W'(DIV1000_MUL);
		q1          = {1'b0, prod1[DIV1000_SHIFT +: QUOT_W]};
		scaled_next = diff1[SAMPLE_W] ? (~q1 + 8'd1) : q1;
	end

	// (90*old + 10*new)/100 equals (9*old + new)/10
	always_comb begin
		old_ext   = {{(SUM_W-RATE_W){rate_filter_q[RATE_W-1]}}, rate_filter_q};
		new_ext   = {{(SUM_W-RATE_W){scaled_s1[RATE_W-1]}}, scaled_s1};
		sum2      = (old_ext <<< 3) + old_ext + new_ext;
		neg_sum2  = -sum2;
		mag2      = sum2[SUM_W-1] ? neg_sum2[MAG2_W-1:0] : sum2[MAG2_W-1:0];
		prod2     = PROD2_W'(mag2) * PROD2_W'(DIV10_MUL);
		q2        = {1'b0, prod2[DIV10_SHIFT +: QUOT_W]};
		filt_next = sum2[SUM_W-1] ? (~q2 + 8'd1) : q2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			rate_filter_q <= '0;
		end else begin
			if (samples.ready) begin
				v_s1 <= samples.valid;
			end
			if (ready2) begin
				v_s2 <= v_s1;
			end
			if (v_s1 && ready2) begin
				rate_filter_q <= signed'(filt_next);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			scaled_s1 <= signed'(scaled_next);
		end
	end

endmodule

>>> sv/grd_ramp_track.sv
// Zero-rate run counter, angle integrator with history, ramp and lockout logic.
module grd_ramp_track import grd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	grd_rate_if.sink      rate,
	grd_result_if.source  results
);

	logic                      v_s3;
	logic signed [RATE_W-1:0]  filt_s3;
	logic                      flat_s3;
	ramp_kind_t                ramp_s3;
	logic signed [ANGLE_W-1:0] hist_q [HISTORY_DEPTH];
	logic [RUN_W-1:0]          run_q;
	logic [RELOAD_W-1:0]       lock_cnt_q;
	logic                      lock_q;

	logic                      ld;
	logic [RUN_W-1:0]          run_next;
	logic                      flat;
	logic signed [ANGLE_W-1:0] base;
	logic signed [ANGLE_W-1:0] oldest;
	logic signed [ANGLE_W-1:0] angle_next;
	logic signed [ANGLE_W:0]   diff_fall;
	logic signed [ANGLE_W:0]   diff_rise;
	logic signed [ANGLE_W:0]   thr;
	ramp_kind_t                ramp;
	logic [RELOAD_W-1:0]       cnt_dec;
	logic [RELOAD_W-1:0]       lock_cnt_next;
	logic                      lock_next;

	assign rate.ready = !v_s3 || results.ready;
	assign ld         = rate.valid && rate.ready;

	always_comb begin
		priority if (rate.rate != '0) begin
			run_next = '0;
		end else if (run_q[RUN_W-1]) begin
			run_next = run_q;
		end else begin
			run_next = run_q + 1'b1;
		end
		flat = run_next > {1'b0, cfg.flat_tick_limit};
	end

	always_comb begin
		base       = flat ? '0 : hist_q[HISTORY_DEPTH-1];
		oldest     = flat ? '0 : hist_q[1];
		angle_next = base + {{(ANGLE_W-RATE_W){rate.rate[RATE_W-1]}}, rate.rate};
		diff_fall  = {oldest[ANGLE_W-1], oldest} - {angle_next[ANGLE_W-1], angle_next};
		diff_rise  = {angle_next[ANGLE_W-1], angle_next} - {oldest[ANGLE_W-1], oldest};
		thr        = signed'({2'b00, cfg.ramp_threshold});
		priority if (angle_next < 0 && oldest < 0 && diff_fall > thr) begin
			ramp = RAMP_FALL;
		end else if (angle_next > 0 && oldest > 0 && diff_rise > thr) begin
			ramp = RAMP_RISE;
		end else begin
			ramp = RAMP_NONE;
		end
	end

	always_comb begin
		cnt_dec = (lock_cnt_q != '0) ? lock_cnt_q - 1'b1 : lock_cnt_q;
		priority if (ramp == RAMP_FALL) begin
			lock_next     = 1'b1;
			lock_cnt_next = cfg.lockout_reload;
		end else if (ramp == RAMP_RISE || cnt_dec == '0) begin
			lock_next     = 1'b0;
			lock_cnt_next = cnt_dec;
		end else begin
			lock_next     = lock_q;
			lock_cnt_next = cnt_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3       <= 1'b0;
			run_q      <= '0;
			lock_cnt_q <= '0;
			lock_q     <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (rate.ready) begin
				v_s3 <= rate.valid;
			end
			if (ld) begin
				run_q      <= run_next;
				lock_cnt_q <= lock_cnt_next;
				lock_q     <= lock_next;
				for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
					hist_q[i] <= flat ? '0 : hist_q[i+1];
				end
				hist_q[HISTORY_DEPTH-1] <= angle_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			filt_s3 <= rate.rate;
			flat_s3 <= flat;
			ramp_s3 <= ramp;
		end
	end

	assign results.valid         = v_s3;
	assign results.filtered_rate = filt_s3;
	assign results.angle         = hist_q[HISTORY_DEPTH-1];
	assign results.flat_flag     = flat_s3;
	assign results.ramp_kind     = ramp_s3;
	assign results.lockout_flag  = lock_q;

endmodule

>>> sv/gyro_ramp_detector.sv
// Top level of the gyro ramp detector: configuration registers and the rate pipeline.
// A result is valid once its accepted sample beat has passed the s1, s2 and s3 registers.
// Throughput: one sample per cycle; the three pipeline registers hold under output stall.
// The filter state and the angle history each close their loop inside one stage.
// Reset: asynchronous, active low; clears filter, run count, angle history and lockout,
// and loads the configuration registers with their default values.
module gyro_ramp_detector import grd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	grd_cfg_if.sink      cfg,
	grd_sample_if.sink   samples,
	grd_result_if.source results
);

	cfg_t cfg_q;

	grd_rate_if rate_ch ();

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_offset     <= RATE_OFFSET_RST;
			cfg_q.flat_tick_limit <= FLAT_TICK_LIMIT_RST;
			cfg_q.ramp_threshold  <= RAMP_THRESHOLD_RST;
			cfg_q.lockout_reload  <= LOCKOUT_RELOAD_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_RATE_OFFSET:     cfg_q.rate_offset     <= cfg.data[SAMPLE_W-1:0];
				CFG_FLAT_TICK_LIMIT: cfg_q.flat_tick_limit <= cfg.data[LIMIT_W-1:0];
				CFG_RAMP_THRESHOLD:  cfg_q.ramp_threshold  <= cfg.data[THRESH_W-1:0];
				CFG_LOCKOUT_RELOAD:  cfg_q.lockout_reload  <= cfg.data[RELOAD_W-1:0];
			endcase
		end
	end

	grd_rate_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.samples (samples),
		.rate    (rate_ch)
	);

	grd_ramp_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.rate    (rate_ch),
		.results (results)
	);

endmodule

>>> sv/grd_checker.sv
// Port-level checks on the result channel of the gyro ramp detector, bound to the top.
module grd_checker import grd_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [RATE_W-1:0]  filtered_rate,
	input logic signed [ANGLE_W-1:0] angle,
	input logic                      flat_flag,
	input logic [RAMP_W-1:0]         ramp_kind,
	input logic                      lockout_flag
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(filtered_rate)
			&& $stable(ramp_kind) && $stable(lockout_flag) && $stable(flat_flag))
		else $error("result beat changed while stalled");

	a_flat_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flat_flag |->
			angle == {{(ANGLE_W-RATE_W){filtered_rate[RATE_W-1]}}, filtered_rate})
		else $error("flat beat angle not restarted from the filtered rate");

	a_flat_no_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flat_flag |-> ramp_kind == RAMP_NONE)
		else $error("ramp reported on a flat beat");

	a_fall_locks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ramp_kind == RAMP_FALL |-> lockout_flag)
		else $error("falling ramp without lockout");

	a_rise_unlocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ramp_kind == RAMP_RISE |-> !lockout_flag)
		else $error("rising ramp with lockout still active");

endmodule

bind gyro_ramp_detector grd_checker u_grd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.filtered_rate (results.filtered_rate),
	.angle         (results.angle),
	.flat_flag     (results.flat_flag),
	.ramp_kind     (results.ramp_kind),
	.lockout_flag  (results.lockout_flag)
);

>>> test/tb_gyro_ramp_detector.sv
`timescale 1ns / 1ps
// Self-checking testbench for gyro_ramp_detector: predicted tick results against the handshaked output.
module tb_gyro_ramp_detector;
	import grd_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic signed [RATE_W-1:0]  rate;
		logic signed [ANGLE_W-1:0] angle;
		logic                      flat;
		ramp_kind_t                ramp;
		logic                      lock;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;
	int   mismatch_count;
	int   stall_left;

	logic [SAMPLE_W-1:0] rate_offs;
	logic [LIMIT_W-1:0]  flat_limit;
	logic [THRESH_W-1:0] ramp_thresh;
	logic [RELOAD_W-1:0] lock_reload;

	int                  filt_rate;
	logic [31:0]         zero_run;
	logic [ANGLE_W-1:0]  angle_acc;
	logic [ANGLE_W-1:0]  angle_hist [HISTORY_DEPTH];
	logic [RELOAD_W-1:0] lock_count;
	logic                lock_state;

	tick_result_t expected_ticks [$];

	grd_cfg_if    cfg_ch ();
	grd_sample_if sample_ch ();
	grd_result_if result_ch ();

	gyro_ramp_detector i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.samples (sample_ch),
		.results (result_ch)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic tick_result_t advance_tick(input logic [SAMPLE_W-1:0] s);
		int           scaled;
		int           oldest;
		int           newest;
		int           i;
		tick_result_t r;
		scaled = (int'(s) - int'(rate_offs)) / 1000;
		filt_rate = (filt_rate * 90 + scaled * 10) / 100;
		if (filt_rate == 0) begin
			if (zero_run != '1)
				zero_run = zero_run + 1;
		end else begin
			zero_run = '0;
		end
		r.flat = zero_run > 32'(flat_limit);
		if (r.flat) begin
			angle_acc = '0;
			for (i = 0; i < HISTORY_DEPTH; i++)
				angle_hist[i] = '0;
		end
		angle_acc = angle_acc + ANGLE_W'(filt_rate);
		for (i = 0; i < HISTORY_DEPTH - 1; i++)
			angle_hist[i] = angle_hist[i + 1];
		angle_hist[HISTORY_DEPTH - 1] = angle_acc;
		oldest = int'($signed(angle_hist[0]));
		newest = int'($signed(angle_hist[HISTORY_DEPTH - 1]));
		r.ramp = RAMP_NONE;
		if (newest < 0 && oldest < 0 && oldest - newest > int'(ramp_thresh))
			r.ramp = RAMP_FALL;
		else if (newest > 0 && oldest > 0 && newest - oldest > int'(ramp_thresh))
			r.ramp = RAMP_RISE;
		if (lock_count != 0)
			lock_count = lock_count - 1;
		if (r.ramp == RAMP_FALL) begin
			lock_state = 1'b1;
			lock_count = lock_reload;
		end else if (r.ramp == RAMP_RISE || lock_count == 0) begin
			lock_state = 1'b0;
		end
		r.rate  = RATE_W'(filt_rate);
		r.angle = angle_acc;
		r.lock  = lock_state;
		return r;
	endfunction

	// call at a falling edge; returns at a falling edge with valid still high
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		expected_ticks.push_back(advance_tick(s));
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			CFG_RATE_OFFSET:     rate_offs   = d;
			CFG_FLAT_TICK_LIMIT: flat_limit  = d;
			CFG_RAMP_THRESHOLD:  ramp_thresh = d[THRESH_W-1:0];
			CFG_LOCKOUT_RELOAD:  lock_reload = d[RELOAD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// upper data bits beyond the threshold and reload register widths carry junk
	task automatic write_regs(input logic [SAMPLE_W-1:0] offs, input logic [LIMIT_W-1:0] lim,
		input logic [THRESH_W-1:0] thr, input logic [RELOAD_W-1:0] rel);
		write_reg(CFG_RATE_OFFSET, offs);
		write_reg(CFG_FLAT_TICK_LIMIT, lim);
		write_reg(CFG_RAMP_THRESHOLD, {1'($urandom), thr});
		write_reg(CFG_LOCKOUT_RELOAD, {8'($urandom), rel});
	endtask

	task automatic drain_ticks();
		sample_ch.valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic test_reset_defaults();
		logic [SAMPLE_W-1:0] pat [10];
		pat = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd999, 16'd1000, 16'h8000, 16'h5555, 16'hAAAA,
			16'd0, 16'd0};
		foreach (pat[i])
			send_sample(pat[i]);
	endtask

	task automatic test_config_extremes();
		logic [SAMPLE_W-1:0] pat [12];
		pat = '{16'hFFFF, 16'd64536, 16'd64535, 16'd0, 16'd0, 16'd0, 16'd1, 16'h7FFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		drain_ticks();
		write_regs(16'hFFFF, 16'd0, 15'h7FFF, 8'hFF);
		foreach (pat[i])
			send_sample(pat[i]);
	endtask

	task automatic test_angle_wrap();
		bit up;
		up = $urandom_range(0, 1);
		drain_ticks();
		write_regs(up ? 16'd0 : 16'hFFFF, 16'hFFFF, 15'($urandom_range(50, 400)),
			8'($urandom_range(1, 255)));
		repeat (650)
			send_sample(up ? 16'($urandom_range(62000, 65535)) : 16'($urandom_range(0, 3535)));
	endtask

	task automatic run_segments(input int n_items);
		int left;
		int len;
		int center;
		int spread;
		int s;
		int kind;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 40);
			if (len > left)
				len = left;
			kind = $urandom_range(0, 3);
			case (kind)
				0: begin
					center = int'(rate_offs);
					spread = 900;
				end
				1: begin
					center = int'(rate_offs) + ($urandom_range(0, 1) ? 1 : -1) *
						int'($urandom_range(1000, 65535));
					spread = 500;
				end
				default: begin
					center = $urandom_range(0, 65535);
					spread = 3000;
				end
			endcase
			repeat (len) begin
				if (kind == 3)
					s = $urandom_range(0, 65535);
				else
					s = center + int'($urandom_range(0, 2 * spread)) - spread;
				if (s < 0)
					s = 0;
				if (s > 65535)
					s = 65535;
				send_sample(16'(s));
			end
			left -= len;
		end
	endtask

	task automatic test_random_segments();
		logic [SAMPLE_W-1:0] offs;
		logic [LIMIT_W-1:0]  lim;
		logic [THRESH_W-1:0] thr;
		for (int round = 0; round < 6; round++) begin
			drain_ticks();
			case ($urandom_range(0, 3))
				0: offs = 16'd0;
				1: offs = 16'hFFFF;
				2: offs = 16'h8000;
				default: offs = 16'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: lim = 16'hFFFF;
				1: lim = 16'($urandom);
				default: lim = 16'($urandom_range(0, 30));
			endcase
			case ($urandom_range(0, 5))
				0: thr = 15'h7FFF;
				1: thr = 15'($urandom);
				default: thr = 15'($urandom_range(0, 200));
			endcase
			if (round == 0)
				write_regs(16'h8000, 16'd5, 15'd0, 8'd0);
			else
				write_regs(offs, lim, thr, 8'($urandom));
			steady = (round == 1);
			run_segments($urandom_range(100, 150));
			steady = 1'b0;
		end
	endtask

	always @(negedge clk) begin
		if (steady) begin
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			stall_left = pick_gap();
			result_ch.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		tick_result_t want;
		tick_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.rate  = result_ch.filtered_rate;
			got.angle = result_ch.angle;
			got.flat  = result_ch.flat_flag;
			got.ramp  = ramp_kind_t'(result_ch.ramp_kind);
			got.lock  = result_ch.lockout_flag;
			if (expected_ticks.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result beat: rate %0d angle %0d flat %b ramp %0d lock %b",
						got.rate, got.angle, got.flat, got.ramp, got.lock);
			end else begin
				want = expected_ticks.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: rate %0d/%0d angle %0d/%0d flat %b/%b ramp %0d/%0d lock %b/%b (exp/act)",
							want.rate, got.rate, want.angle, got.angle, want.flat, got.flat,
							want.ramp, got.ramp, want.lock, got.lock);
				end
			end
		end
	end

	initial begin
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = CFG_RATE_OFFSET;
		cfg_ch.data      = '0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		result_ch.ready  = 1'b0;
		arst_n           = 1'b0;
		steady           = 1'b0;
		mismatch_count   = 0;
		stall_left       = 0;
		rate_offs        = RATE_OFFSET_RST;
		flat_limit       = FLAT_TICK_LIMIT_RST;
		ramp_thresh      = RAMP_THRESHOLD_RST;
		lock_reload      = LOCKOUT_RELOAD_RST;
		filt_rate        = 0;
		zero_run         = '0;
		angle_acc        = '0;
		foreach (angle_hist[i])
			angle_hist[i] = '0;
		lock_count       = '0;
		lock_state       = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_angle_wrap();
		test_random_segments();
		drain_ticks();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
sv/grd_pkg.sv
sv/grd_ifs.sv
sv/grd_rate_front.sv
sv/grd_ramp_track.sv
sv/gyro_ramp_detector.sv
sv/grd_checker.sv
test/tb_gyro_ramp_detector.sv
